>>> rtl/u8u16_pkg.sv
package u8u16_pkg;

  localparam int unsigned ACC_W   = 26;
  localparam int unsigned PEND_W  = 3;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF7;
  localparam logic [BYTE_W-1:0] LEAD5_MIN  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD5_MAX  = 8'hFB;

  localparam logic [1:0]  CONT_TAG     = 2'b10;
  localparam logic [5:0]  HI_SURR_TAG  = 6'b110110;
  localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [4:0]  PLANE_MAX    = 5'h10;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last_unit;
  } out_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [PEND_W-1:0] pend;
  } dec_state_t;

  typedef struct packed {
    dec_state_t  state;
    logic [1:0]  count;
    out_item_t   unit0;
    out_item_t   unit1;
  } dec_res_t;

endpackage

>>> rtl/u8u16_dec.sv
module u8u16_dec (
  input  u8u16_pkg::in_item_t   item,
  input  u8u16_pkg::dec_state_t state,
  output u8u16_pkg::dec_res_t   res
);
  import u8u16_pkg::*;

  logic [BYTE_W-1:0] b;
  logic [ACC_W-1:0]  acc_shift;
  logic [PEND_W-1:0] pend_dec;
  logic [20:0]       supp;

  assign b         = item.byte_in;
  assign acc_shift = {state.acc[ACC_W-7:0], b[5:0]};
  assign pend_dec  = state.pend - PEND_W'(1);
  assign supp      = acc_shift[20:0] - SUPP_BASE;

  always_comb begin
    res.state = state;
    res.count = 2'd0;
    res.unit0 = '0;
    res.unit1 = '0;
    if (state.pend == '0) begin
      case (b) inside
        [8'h00:ASCII_MAX]: begin
          res.unit0 = '{code_unit: {8'h00, b}, last_unit: 1'b1};
          res.count = 2'd1;
        end
        [LEAD2_MIN:LEAD2_MAX]: begin
          res.state.acc  = ACC_W'(b[4:0]);
          res.state.pend = PEND_W'(1);
        end
        [LEAD3_MIN:LEAD3_MAX]: begin
          res.state.acc  = ACC_W'(b[3:0]);
          res.state.pend = PEND_W'(2);
        end
        [LEAD4_MIN:LEAD4_MAX]: begin
          res.state.acc  = ACC_W'(b[2:0]);
          res.state.pend = PEND_W'(3);
        end
        [LEAD5_MIN:LEAD5_MAX]: begin
          res.state.acc  = ACC_W'(b[1:0]);
          res.state.pend = PEND_W'(4);
        end
        default: begin
          res.state = state;
        end
      endcase
    end else if (b[7:6] == CONT_TAG) begin
      res.state.acc  = acc_shift;
      res.state.pend = pend_dec;
      if (pend_dec == '0) begin
        res.state.acc = '0;
        if (acc_shift[ACC_W-1:16] == '0) begin
          res.unit0 = '{code_unit: acc_shift[15:0], last_unit: 1'b1};
          res.count = 2'd1;
        end else if (acc_shift[ACC_W-1:21] == '0 && acc_shift[20:16] <= PLANE_MAX) begin
          res.unit0 = '{code_unit: {HI_SURR_TAG, supp[19:10]}, last_unit: 1'b0};
          res.unit1 = '{code_unit: {LO_SURR_TAG, supp[9:0]}, last_unit: 1'b1};
          res.count = 2'd2;
        end
      end
    end else begin
      // bad continuation aborts the open sequence
      res.state = '0;
    end
    if (item.end_of_string) begin
      res.state = '0;
    end
  end

endmodule

>>> rtl/utf8_to_utf16_decoder.sv
// channel | ports                          | moves
// input   | in_valid, in_stall, in_data    | one utf-8 byte and end flag per transfer
// output  | out_valid, out_stall, out_data | one utf-16 unit per transfer
// one byte is taken per cycle while in_stall is low; a result passes the input stage register, then the output queue
// a surrogate pair is sent as two units, buffered in a two-slot output queue
// input stalls only when the output queue cannot take the units of the held byte
// rst_n is synchronous and clears the decode state, input stage and queue
module utf8_to_utf16_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u8u16_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u8u16_pkg::out_item_t  out_data
);
  import u8u16_pkg::*;

  logic       in_vld_r;
  in_item_t   in_item_r;
  dec_state_t state_r;
  dec_res_t   res;
  out_item_t  q0_r, q0_nxt;
  out_item_t  q1_r, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] cnt_left;
  logic       pop;
  logic       adv;

  u8u16_dec u_dec (
    .item  (in_item_r),
    .state (state_r),
    .res   (res)
  );

  assign pop      = (cnt_r != 2'd0) && !out_stall;
  assign cnt_left = cnt_r - {1'b0, pop};
  assign adv      = in_vld_r && ({1'b0, cnt_left} + {1'b0, res.count} <= 3'd2);
  assign in_stall = in_vld_r && !adv;

  always_comb begin
    out_item_t head;
    head    = pop ? q1_r : q0_r;
    q0_nxt  = (cnt_left == 2'd0) ? res.unit0 : head;
    q1_nxt  = (cnt_left == 2'd0) ? res.unit1 :
              (cnt_left == 2'd1) ? res.unit0 : q1_r;
    cnt_nxt = adv ? (cnt_left + res.count) : cnt_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= '0;
      cnt_r    <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        state_r <= res.state;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

endmodule

>>> rtl/u8u16_chk.sv
module u8u16_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input u8u16_pkg::out_item_t out_data
);
  import u8u16_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  a_high_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_unit |-> out_data.code_unit[15:10] == HI_SURR_TAG)
    else $error("non-final unit is not a high surrogate");

  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_unit |=>
      out_valid && out_data.last_unit && out_data.code_unit[15:10] == LO_SURR_TAG)
    else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_decoder u8u16_chk u_chk (.*);
